[rtl/sphm_pkg.sv]
// Package: shared sizes, codes, types and the bar memory control bundle.
package sphm_pkg;

   localparam int RING_SIZE = 1024;
   localparam int NUM_BARS  = 16;

   localparam int RING_AW  = $clog2(RING_SIZE);
   localparam int CNT_W    = $clog2(RING_SIZE + 1);
   localparam int BAR_W    = $clog2(NUM_BARS);
   localparam int LEVEL_W  = 16;
   localparam int GAIN_W   = 16;
   localparam int SAMPLE_W = 16;
   localparam int INDEX_W  = 4;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [LEVEL_W-1:0] FULL_SCALE       = 16'd32768;
   localparam logic [GAIN_W-1:0]  RELEASE_GAIN_RST = 16'd22282;
   localparam logic [LEVEL_W-1:0] IDLE_LEVEL_RST   = 16'd66;

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_TICK   = 2'd1,
      KIND_RESYNC = 2'd2
   } kind_type;

   typedef enum logic {
      REG_RELEASE_GAIN = 1'b0,
      REG_IDLE_LEVEL   = 1'b1
   } reg_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PRIME,
      ST_UPDATE,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] target;
      logic [LEVEL_W-1:0] shown;
   } bar_entry_type;

   typedef struct packed {
      logic             rd_en;
      logic [BAR_W-1:0] rd_addr;
      logic             upd_en;
      logic [BAR_W-1:0] wr_addr;
      logic             newest;
      logic             max_clr;
   } bar_ctl_type;

endpackage

[rtl/sphm_bar_engine.sv]
// Bar history memory with release ballistics and running maximum of shown levels.
module sphm_bar_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  sphm_pkg::bar_ctl_type         ctl,
   input  logic [sphm_pkg::LEVEL_W-1:0]  peak,
   input  logic [sphm_pkg::GAIN_W-1:0]   release_gain,
   output logic [sphm_pkg::LEVEL_W-1:0]  shown_q,
   output logic [sphm_pkg::LEVEL_W-1:0]  max_q
);

   sphm_pkg::bar_entry_type bar_mem [sphm_pkg::NUM_BARS];
   sphm_pkg::bar_entry_type rd_ff;
   logic [sphm_pkg::NUM_BARS-1:0] valid_ff;
   logic [sphm_pkg::LEVEL_W-1:0]  max_ff;

   logic [sphm_pkg::LEVEL_W-1:0]  tgt;
   logic [sphm_pkg::LEVEL_W-1:0]  shn;
   logic [sphm_pkg::LEVEL_W-1:0]  diff;
   logic [2*sphm_pkg::LEVEL_W-1:0] prod;
   logic [2*sphm_pkg::LEVEL_W-1:0] prod_up;
   logic [sphm_pkg::LEVEL_W-1:0]  step;
   sphm_pkg::bar_entry_type       upd;

   // ceil of the product keeps the floor of the negative step
   always_comb begin
      tgt     = ctl.newest ? peak : rd_ff.target;
      shn     = rd_ff.shown;
      diff    = shn - tgt;
      prod    = 32'(diff) * 32'(release_gain);
      prod_up = prod + 32'h0000_FFFF;
      step    = prod_up[2*sphm_pkg::LEVEL_W-1:sphm_pkg::LEVEL_W];
      upd.target = tgt;
      upd.shown  = (tgt >= shn) ? tgt : (shn - step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.upd_en) begin
         valid_ff[ctl.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.upd_en) begin
         bar_mem[ctl.wr_addr] <= upd;
      end
      if (ctl.rd_en) begin
         rd_ff <= valid_ff[ctl.rd_addr] ? bar_mem[ctl.rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.max_clr) begin
         max_ff <= '0;
      end else if (ctl.upd_en && (upd.shown > max_ff)) begin
         max_ff <= upd.shown;
      end
   end

   assign shown_q = rd_ff.shown;
   assign max_q   = max_ff;

endmodule

[rtl/scrolling_peak_history_meter_core.sv]
// Top level: sample ring, tick sequencer, configuration registers and result register.
// Sample, resync and unused items may follow back to back while the core is idle.
// A tick scans the samples counted since the previous tick, up to RING_SIZE and none
// after a resync: one ring read per cycle on its single read port, then one bar memory
// access per cycle for the update pass and again for the output pass, whose reads wait
// while a result is still waiting to be taken.
// Synchronous reset clears control state at once; no clearing pass is needed.
module scrolling_peak_history_meter_core (
   input  logic                           clock,
   input  logic                           reset,
   // input stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [sphm_pkg::SAMPLE_W-1:0]  req_tdata,   // [15:0] sample
   input  logic [1:0]                     req_tuser,   // [1:0] kind
   // result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,   // [3:0] bar_index, [19:4] bar_level
   output logic                           rsp_tuser,   // [0] redraw
   output logic                           rsp_tlast,   // last_bar
   // configuration port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sphm_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [sphm_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [sphm_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                           csr_pready
);

   localparam int N_BARS = sphm_pkg::NUM_BARS;
   localparam int BAR_W  = sphm_pkg::BAR_W;
   localparam int RING_AW = sphm_pkg::RING_AW;
   localparam int CNT_W  = sphm_pkg::CNT_W;
   localparam int LVL_W  = sphm_pkg::LEVEL_W;
   localparam int INDEX_W_L = sphm_pkg::INDEX_W;

   // bar slot of history position k; oldest bar after the scroll sits one past base
   function automatic logic [BAR_W-1:0] bar_slot(input logic [BAR_W-1:0] base,
                                                input logic [BAR_W-1:0] k);
      logic [BAR_W:0] s;
      s = {1'b0, base} + {1'b0, k} + (BAR_W+1)'(1);
      if (s >= (BAR_W+1)'(N_BARS)) begin
         s = s - (BAR_W+1)'(N_BARS);
      end
      return s[BAR_W-1:0];
   endfunction

   // ---------------------------------------------------------------- registers
   sphm_pkg::state_type state_ff, state_in;
   logic [RING_AW-1:0]  wpos_ff, wpos_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                skip_ff, skip_in;
   logic [LVL_W-1:0]    last_peak_ff, last_peak_in;
   logic [sphm_pkg::GAIN_W-1:0] gain_ff, gain_in;
   logic [LVL_W-1:0]    idle_ff, idle_in;
   logic [BAR_W-1:0]    base_ff, base_in;
   logic [BAR_W-1:0]    k_ff, k_in;
   logic [CNT_W-1:0]    scan_left_ff, scan_left_in;
   logic [RING_AW-1:0]  scan_ptr_ff, scan_ptr_in;
   logic                scan_vld_ff, scan_vld_in;
   logic [LVL_W-1:0]    peak_ff, peak_in;
   logic                redraw_ff, redraw_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W_L-1:0] rsp_index_ff, rsp_index_in;
   logic [LVL_W-1:0]    rsp_level_ff, rsp_level_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_redraw_ff, rsp_redraw_in;

   // ring memory: one write port for samples, one registered read port for the scan
   logic [sphm_pkg::SAMPLE_W-1:0] ring_mem [sphm_pkg::RING_SIZE];
   logic [sphm_pkg::SAMPLE_W-1:0] ring_q_ff;
   logic                          ring_we;
   logic                          ring_re;

   sphm_pkg::bar_ctl_type bar_ctl;
   logic [LVL_W-1:0]      bar_shown;
   logic [LVL_W-1:0]      bar_max;

   logic                  req_xfer;
   logic                  rsp_xfer;
   logic                  csr_wr;
   sphm_pkg::kind_type    kind;
   logic [LVL_W-1:0]      mag;
   logic                  is_idle;
   logic                  load_ok;
   logic [BAR_W-1:0]      k_next;
   logic [BAR_W-1:0]      last_k;

   assign req_xfer = req_tvalid & req_tready;
   assign rsp_xfer = rsp_valid_ff & rsp_tready;
   assign csr_wr   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign kind     = sphm_pkg::kind_type'(req_tuser);
   assign k_next   = k_ff + BAR_W'(1);
   assign last_k   = BAR_W'(N_BARS - 1);

   // magnitude of a signed sample; the most negative value maps to full scale
   assign mag = ring_q_ff[LVL_W-1] ? (~ring_q_ff + LVL_W'(1)) : ring_q_ff;

   assign is_idle = (bar_max < idle_ff) && (last_peak_ff < idle_ff);
   assign load_ok = !rsp_valid_ff || rsp_tready;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      wpos_in      = wpos_ff;
      cnt_in       = cnt_ff;
      skip_in      = skip_ff;
      last_peak_in = last_peak_ff;
      base_in      = base_ff;
      k_in         = k_ff;
      scan_left_in = scan_left_ff;
      scan_ptr_in  = scan_ptr_ff;
      scan_vld_in  = 1'b0;
      peak_in      = peak_ff;
      redraw_in    = redraw_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_index_in = rsp_index_ff;
      rsp_level_in = rsp_level_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_redraw_in = rsp_redraw_ff;
      req_tready   = 1'b0;
      ring_we      = 1'b0;
      ring_re      = 1'b0;
      bar_ctl      = '0;

      unique case (state_ff)
         sphm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_xfer) begin
               case (kind)
                  sphm_pkg::KIND_SAMPLE: begin
                     ring_we = 1'b1;
                     wpos_in = (wpos_ff == RING_AW'(sphm_pkg::RING_SIZE - 1)) ?
                               '0 : wpos_ff + RING_AW'(1);
                     if (cnt_ff != CNT_W'(sphm_pkg::RING_SIZE)) begin
                        cnt_in = cnt_ff + CNT_W'(1);
                     end
                  end
                  sphm_pkg::KIND_TICK: begin
                     scan_left_in = skip_ff ? '0 : cnt_ff;
                     scan_ptr_in  = (wpos_ff == '0) ?
                                    RING_AW'(sphm_pkg::RING_SIZE - 1) :
                                    wpos_ff - RING_AW'(1);
                     skip_in      = 1'b0;
                     cnt_in       = '0;
                     peak_in      = '0;
                     state_in     = sphm_pkg::ST_SCAN;
                  end
                  sphm_pkg::KIND_RESYNC: begin
                     skip_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // newest first; the read order does not matter to a maximum
         sphm_pkg::ST_SCAN: begin
            if (scan_vld_ff && (mag > peak_ff)) begin
               peak_in = mag;
            end
            if (scan_left_ff != '0) begin
               ring_re      = 1'b1;
               scan_vld_in  = 1'b1;
               scan_left_in = scan_left_ff - CNT_W'(1);
               scan_ptr_in  = (scan_ptr_ff == '0) ?
                              RING_AW'(sphm_pkg::RING_SIZE - 1) :
                              scan_ptr_ff - RING_AW'(1);
            end else if (!scan_vld_ff) begin
               state_in = sphm_pkg::ST_PRIME;
            end
         end

         sphm_pkg::ST_PRIME: begin
            bar_ctl.rd_en   = 1'b1;
            bar_ctl.rd_addr = bar_slot(base_ff, '0);
            bar_ctl.max_clr = 1'b1;
            k_in            = '0;
            state_in        = sphm_pkg::ST_UPDATE;
         end

         // the newest bar keeps the old newest shown level, still held in the read
         // register since the second newest bar was fetched
         sphm_pkg::ST_UPDATE: begin
            bar_ctl.upd_en  = 1'b1;
            bar_ctl.wr_addr = bar_slot(base_ff, k_ff);
            bar_ctl.newest  = (k_ff == last_k);
            if (k_ff < BAR_W'(N_BARS - 2)) begin
               bar_ctl.rd_en   = 1'b1;
               bar_ctl.rd_addr = bar_slot(base_ff, k_next);
            end
            if (k_ff == last_k) begin
               k_in     = '0;
               state_in = sphm_pkg::ST_DECIDE;
            end else begin
               k_in = k_next;
            end
         end

         sphm_pkg::ST_DECIDE: begin
            redraw_in = !is_idle;
            if (!is_idle) begin
               last_peak_in = bar_max;
            end
            bar_ctl.rd_en   = 1'b1;
            bar_ctl.rd_addr = bar_slot(base_ff, '0);
            state_in        = sphm_pkg::ST_EMIT;
         end

         // the redraw flag travels with each transfer; the final bar of the previous
         // tick may still be waiting when this tick decides
         sphm_pkg::ST_EMIT: begin
            if (load_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = INDEX_W_L'(k_ff);
               rsp_level_in  = bar_shown;
               rsp_last_in   = (k_ff == last_k);
               rsp_redraw_in = redraw_ff;
               if (k_ff == last_k) begin
                  base_in  = bar_slot(base_ff, '0);
                  k_in     = '0;
                  state_in = sphm_pkg::ST_IDLE;
               end else begin
                  bar_ctl.rd_en   = 1'b1;
                  bar_ctl.rd_addr = bar_slot(base_ff, k_next);
                  k_in            = k_next;
               end
            end
         end

         default: begin
            state_in = sphm_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- config port
   always_comb begin
      gain_in = gain_ff;
      idle_in = idle_ff;
      if (csr_wr) begin
         unique case (sphm_pkg::reg_idx_type'(csr_paddr[2]))
            sphm_pkg::REG_RELEASE_GAIN: gain_in = csr_pwdata[sphm_pkg::GAIN_W-1:0];
            sphm_pkg::REG_IDLE_LEVEL:   idle_in = csr_pwdata[LVL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (sphm_pkg::reg_idx_type'(csr_paddr[2]))
         sphm_pkg::REG_RELEASE_GAIN: csr_prdata = sphm_pkg::CSR_DW'(gain_ff);
         sphm_pkg::REG_IDLE_LEVEL:   csr_prdata = sphm_pkg::CSR_DW'(idle_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // ---------------------------------------------------------------- storage
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sphm_pkg::ST_IDLE;
         wpos_ff      <= '0;
         cnt_ff       <= '0;
         skip_ff      <= 1'b1;
         last_peak_ff <= '0;
         gain_ff      <= sphm_pkg::RELEASE_GAIN_RST;
         idle_ff      <= sphm_pkg::IDLE_LEVEL_RST;
         base_ff      <= '0;
         k_ff         <= '0;
         scan_left_ff <= '0;
         scan_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wpos_ff      <= wpos_in;
         cnt_ff       <= cnt_in;
         skip_ff      <= skip_in;
         last_peak_ff <= last_peak_in;
         gain_ff      <= gain_in;
         idle_ff      <= idle_in;
         base_ff      <= base_in;
         k_ff         <= k_in;
         scan_left_ff <= scan_left_in;
         scan_vld_ff  <= scan_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff   <= scan_ptr_in;
      peak_ff       <= peak_in;
      redraw_ff     <= redraw_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_redraw_ff <= rsp_redraw_in;
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wpos_ff] <= req_tdata;
      end
      if (ring_re) begin
         ring_q_ff <= ring_mem[scan_ptr_ff];
      end
   end

   sphm_bar_engine u_bars (
      .clock        (clock),
      .reset        (reset),
      .ctl          (bar_ctl),
      .peak         (peak_ff),
      .release_gain (gain_ff),
      .shown_q      (bar_shown),
      .max_q        (bar_max)
   );

   // ---------------------------------------------------------------- outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_level_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_redraw_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(sphm_pkg::RING_SIZE))
      else $error("new sample count past ring size");

   a_scan_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sphm_pkg::ST_SCAN) |-> (scan_left_ff == '0))
      else $error("scan count left over outside the scan");

   a_tick_scan: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (kind == sphm_pkg::KIND_TICK)) |=> (state_ff == sphm_pkg::ST_SCAN))
      else $error("tick transfer did not start the scan");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_level_ff <= sphm_pkg::FULL_SCALE))
      else $error("shown level above full scale");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_index_ff == INDEX_W_L'(N_BARS - 1)))
      else $error("final bar flag on a bar other than the newest");

endmodule
